// ----- sv/thermal_packet_frame_sync_macros.svh -----
// Assertion macros for the thermal packet frame sync block.
`ifndef THERMAL_PACKET_FRAME_SYNC_MACROS_SVH
`define THERMAL_PACKET_FRAME_SYNC_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset.
`define TPFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TPFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TPFS_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define TPFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- sv/tpfs_pkg.sv -----
// Types, codes and constants of the thermal packet frame sync block.
`default_nettype none

package tpfs_pkg;

  localparam int unsigned IMAGE_PACKETS = 60;
  localparam int unsigned SEGMENT_PACKET = 20;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned HEADER_W = 16;
  localparam int unsigned CRC_W = 16;
  localparam int unsigned VERDICT_W = 4;
  localparam int unsigned SEGMENT_W = 3;
  localparam int unsigned RUN_W = 8;
  localparam int unsigned FRAME_NUM_W = 16;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned TELEM_W = 3;
  localparam int unsigned HUNT_W = 12;

  localparam logic [HEADER_W-1:0] SEG_MASK = 16'h7000;
  localparam logic [HEADER_W-1:0] DISCARD_MASK = 16'h0f00;
  localparam logic [HEADER_W-1:0] NUM_MASK = 16'h00ff;

  localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_IS_SEGMENTED = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TELEMETRY_LINES = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DESYNC_LIMIT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HUNT_LIMIT = 2'd3;

  localparam logic [RUN_W-1:0] DESYNC_LIMIT_RESET = 8'd60;
  localparam logic [HUNT_W-1:0] HUNT_LIMIT_RESET = 12'd2000;

  localparam logic OP_FRAME_START = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  localparam logic [VERDICT_W-1:0] V_NONE = 4'd0;
  localparam logic [VERDICT_W-1:0] V_PUBLISHED = 4'd1;
  localparam logic [VERDICT_W-1:0] V_UNPUBLISHED = 4'd2;
  localparam logic [VERDICT_W-1:0] V_REJECTED = 4'd3;
  localparam logic [VERDICT_W-1:0] V_REJECT_HUNT = 4'd4;
  localparam logic [VERDICT_W-1:0] V_RESET_HUNT = 4'd5;
  localparam logic [VERDICT_W-1:0] V_HUNT_ENDED = 4'd6;
  localparam logic [VERDICT_W-1:0] V_HUNT_GAVE_UP = 4'd7;
  localparam logic [VERDICT_W-1:0] V_FAILED = 4'd8;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_COLLECT = 4'b0010,
    MODE_HUNT    = 4'b0100,
    MODE_DRAIN   = 4'b1000
  } mode_t;

endpackage

`default_nettype wire

// ----- sv/thermal_packet_frame_sync.sv -----
// Top level of the thermal packet frame sync block.
`default_nettype none
`include "thermal_packet_frame_sync_macros.svh"

// Takes one word (frame start or packet) per clock and returns exactly one
// result word per input word, in the cycle after it is taken. All frame, hunt
// and drain checks are a single pass of small compares and counters from the
// input ports into the result register, so a word is accepted every cycle;
// in_stall rises only while the result register holds a word that the
// downstream side is stalling. Configuration writes take effect at once and
// belong in idle periods.
module thermal_packet_frame_sync (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tpfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tpfs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic [tpfs_pkg::HEADER_W-1:0]       header,
  input  logic [tpfs_pkg::CRC_W-1:0]          crc_word,
  input  logic                                transfer_ok,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tpfs_pkg::VERDICT_W-1:0]      verdict,
  output logic [tpfs_pkg::SEGMENT_W-1:0]      segment,
  output logic [tpfs_pkg::RUN_W-1:0]          desync_run,
  output logic [tpfs_pkg::RUN_W-1:0]          recovered_after,
  output logic [tpfs_pkg::FRAME_NUM_W-1:0]    frame_number
);
  import tpfs_pkg::*;

  logic                   sensor_is_segmented;
  logic [TELEM_W-1:0]     telemetry_lines;
  logic [RUN_W-1:0]       desync_limit;
  logic [HUNT_W-1:0]      hunt_limit;

  mode_t                  mode, mode_next;
  logic [INDEX_W-1:0]     packet_index, packet_index_next;
  logic [INDEX_W-1:0]     first_number, first_number_next;
  logic [SEGMENT_W-1:0]   frame_segment, frame_segment_next;
  logic                   frame_error, frame_error_next;
  logic [FRAME_NUM_W-1:0] frames_since_resync, frames_since_resync_next;
  logic [RUN_W-1:0]       reject_run, reject_run_next;
  logic [RUN_W-1:0]       reset_count, reset_count_next;
  logic [HUNT_W-1:0]      hunt_tries, hunt_tries_next;

  logic [VERDICT_W-1:0]   verdict_next;
  logic [RUN_W-1:0]       recov_next;

  logic                   accept;
  logic [INDEX_W-1:0]     frame_count;
  logic [INDEX_W-1:0]     index_inc;
  logic [INDEX_W-1:0]     number;
  logic [FRAME_NUM_W-1:0] frames_inc;
  logic [RUN_W-1:0]       reject_inc;
  logic [RUN_W-1:0]       reset_inc;
  logic                   give_up;
  logic                   keep;

  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  assign frame_count = INDEX_W'(IMAGE_PACKETS) + {{(INDEX_W-TELEM_W){1'b0}}, telemetry_lines};
  assign index_inc = packet_index + 1'b1;
  assign number = header[INDEX_W-1:0];
  assign frames_inc = (frames_since_resync == '1) ? frames_since_resync
                                                  : frames_since_resync + 1'b1;
  assign reject_inc = (reject_run == '1) ? reject_run : reject_run + 1'b1;
  assign reset_inc = (reset_count == '1) ? reset_count : reset_count + 1'b1;
  assign give_up = hunt_tries >= hunt_limit;
  assign keep = transfer_ok && (((header & DISCARD_MASK) == DISCARD_MASK)
                || (number != '0) || (crc_word == '0));

  always_comb begin
    mode_next = mode;
    packet_index_next = packet_index;
    first_number_next = first_number;
    frame_segment_next = frame_segment;
    frame_error_next = frame_error;
    frames_since_resync_next = frames_since_resync;
    reject_run_next = reject_run;
    reset_count_next = reset_count;
    hunt_tries_next = hunt_tries;
    verdict_next = V_NONE;
    recov_next = '0;
    if (operation == OP_FRAME_START) begin
      if (mode == MODE_IDLE) begin
        mode_next = MODE_COLLECT;
        packet_index_next = '0;
        frame_error_next = 1'b0;
      end
    end else begin
      unique case (mode)
        MODE_IDLE: begin
        end
        MODE_COLLECT: begin
          if (!transfer_ok) frame_error_next = 1'b1;
          if (packet_index == '0) first_number_next = number;
          if (packet_index == INDEX_W'(SEGMENT_PACKET)) begin
            frame_segment_next = header[14:12];
          end
          packet_index_next = index_inc;
          if (index_inc >= frame_count) begin
            mode_next = MODE_IDLE;
            if (frame_error_next) begin
              verdict_next = V_FAILED;
            end else begin
              frames_since_resync_next = frames_inc;
              if (first_number_next == '0 && number == frame_count - 1'b1) begin
                reject_run_next = '0;
                recov_next = reset_count;
                reset_count_next = '0;
                if (!sensor_is_segmented ||
                    (frame_segment_next >= 3'd1 && frame_segment_next <= 3'd4)) begin
                  verdict_next = V_PUBLISHED;
                end else begin
                  verdict_next = V_UNPUBLISHED;
                end
              end else begin
                reject_run_next = reject_inc;
                priority if (reject_inc >= desync_limit) begin
                  reset_count_next = reset_inc;
                  reject_run_next = '0;
                  frames_since_resync_next = FRAME_NUM_W'(3);
                  verdict_next = V_RESET_HUNT;
                  mode_next = MODE_HUNT;
                  hunt_tries_next = '0;
                end else if (frames_inc > FRAME_NUM_W'(2)) begin
                  verdict_next = V_REJECT_HUNT;
                  mode_next = MODE_HUNT;
                  hunt_tries_next = '0;
                end else begin
                  verdict_next = V_REJECTED;
                end
              end
            end
          end
        end
        MODE_HUNT: begin
          if (!give_up) hunt_tries_next = hunt_tries + 1'b1;
          if (give_up || !keep) begin
            frame_error_next = give_up;
            packet_index_next = '0;
            mode_next = MODE_DRAIN;
          end
        end
        MODE_DRAIN: begin
          packet_index_next = index_inc;
          if (index_inc >= frame_count - 1'b1) begin
            verdict_next = frame_error ? V_HUNT_GAVE_UP : V_HUNT_ENDED;
            frames_since_resync_next = '0;
            mode_next = MODE_IDLE;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_is_segmented <= 1'b0;
      telemetry_lines <= '0;
      desync_limit <= DESYNC_LIMIT_RESET;
      hunt_limit <= HUNT_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SENSOR_IS_SEGMENTED: sensor_is_segmented <= cfg_data[0];
        REG_TELEMETRY_LINES:     telemetry_lines <= cfg_data[TELEM_W-1:0];
        REG_DESYNC_LIMIT:        desync_limit <= cfg_data[RUN_W-1:0];
        REG_HUNT_LIMIT:          hunt_limit <= cfg_data[HUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      packet_index <= '0;
      first_number <= '0;
      frame_segment <= '0;
      frame_error <= 1'b0;
      frames_since_resync <= '0;
      reject_run <= '0;
      reset_count <= '0;
      hunt_tries <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        mode <= mode_next;
        packet_index <= packet_index_next;
        first_number <= first_number_next;
        frame_segment <= frame_segment_next;
        frame_error <= frame_error_next;
        frames_since_resync <= frames_since_resync_next;
        reject_run <= reject_run_next;
        reset_count <= reset_count_next;
        hunt_tries <= hunt_tries_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      verdict <= verdict_next;
      segment <= frame_segment_next;
      desync_run <= reject_run_next;
      recovered_after <= recov_next;
      frame_number <= frames_since_resync_next;
    end
  end

  `TPFS_ASSERT_NOW(a_recov_only_on_accept, clk, rst,
    out_valid && recovered_after != '0,
    verdict == V_PUBLISHED || verdict == V_UNPUBLISHED,
    "recovery count on a non-accepted frame")
  `TPFS_ASSERT_NOW(a_reset_hunt_counts, clk, rst,
    out_valid && verdict == V_RESET_HUNT,
    desync_run == '0 && frame_number == FRAME_NUM_W'(3),
    "hard reset verdict with stale counters")
  `TPFS_ASSERT_NOW(a_hunt_end_clears, clk, rst,
    out_valid && (verdict == V_HUNT_ENDED || verdict == V_HUNT_GAVE_UP),
    frame_number == '0 && mode == MODE_IDLE,
    "hunt end did not resync")
  `TPFS_ASSERT_NEXT(a_start_arms, clk, rst,
    accept && operation == OP_FRAME_START && mode == MODE_IDLE,
    mode == MODE_COLLECT && packet_index == '0 && verdict == V_NONE,
    "frame start in idle did not arm collection")
  `TPFS_ASSERT_NEXT(a_idle_packet_ignored, clk, rst,
    accept && operation == OP_PACKET && mode == MODE_IDLE,
    mode == MODE_IDLE && verdict == V_NONE,
    "packet in idle changed state")

endmodule

`default_nettype wire

// ----- sim/thermal_packet_frame_sync_tb.sv -----
// Testbench for the thermal packet frame sync block: directed and random traffic vs. a predictor.
`timescale 1ns / 100ps

module thermal_packet_frame_sync_tb;
  import tpfs_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [VERDICT_W-1:0]   verdict;
    logic [SEGMENT_W-1:0]   segment;
    logic [RUN_W-1:0]       desync_run;
    logic [RUN_W-1:0]       recovered_after;
    logic [FRAME_NUM_W-1:0] frame_number;
  } sync_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   operation = OP_FRAME_START;
  logic [HEADER_W-1:0]    header = '0;
  logic [CRC_W-1:0]       crc_word = '0;
  logic                   transfer_ok = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [VERDICT_W-1:0]   verdict;
  logic [SEGMENT_W-1:0]   segment;
  logic [RUN_W-1:0]       desync_run;
  logic [RUN_W-1:0]       recovered_after;
  logic [FRAME_NUM_W-1:0] frame_number;

  // predictor copy of the configuration and the sync state
  logic                   cfg_seg_only = 1'b0;
  logic [TELEM_W-1:0]     cfg_telem = '0;
  logic [RUN_W-1:0]       cfg_desync_limit = DESYNC_LIMIT_RESET;
  logic [HUNT_W-1:0]      cfg_hunt_limit = HUNT_LIMIT_RESET;
  mode_t                  sync_mode = MODE_IDLE;
  logic [INDEX_W-1:0]     pkt_index = '0;
  logic [7:0]             first_pkt_num = '0;
  logic [SEGMENT_W-1:0]   frame_seg = '0;
  logic                   frame_err = 1'b0;
  logic [FRAME_NUM_W-1:0] frames_since_resync = '0;
  logic [RUN_W-1:0]       reject_count = '0;
  logic [RUN_W-1:0]       hard_resets = '0;
  logic [HUNT_W-1:0]      hunt_count = '0;

  sync_result_t pending_results[$];
  int  live_words = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  idle_bursts = 1'b1;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;

  thermal_packet_frame_sync i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .header(header),
    .crc_word(crc_word),
    .transfer_ok(transfer_ok),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict(verdict),
    .segment(segment),
    .desync_run(desync_run),
    .recovered_after(recovered_after),
    .frame_number(frame_number)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int packets_per_frame();
    return IMAGE_PACKETS + cfg_telem;
  endfunction

  function automatic sync_result_t track_sync(logic op, logic [HEADER_W-1:0] hdr,
                                              logic [CRC_W-1:0] crc, logic ok);
    sync_result_t res;
    int len;
    logic [7:0] num;
    logic give_up;
    logic keep;
    res = '0;
    len = packets_per_frame();
    num = hdr[7:0];
    if (op == OP_FRAME_START) begin
      if (sync_mode == MODE_IDLE) begin
        sync_mode = MODE_COLLECT;
        pkt_index = '0;
        frame_err = 1'b0;
        live_words++;
      end
    end else begin
      if (sync_mode != MODE_IDLE) live_words++;
      case (sync_mode)
        MODE_COLLECT: begin
          if (!ok) frame_err = 1'b1;
          if (pkt_index == 0) first_pkt_num = num;
          if (pkt_index == SEGMENT_PACKET) frame_seg = hdr[14:12];
          pkt_index = pkt_index + 1'b1;
          if (pkt_index >= len) begin
            sync_mode = MODE_IDLE;
            if (frame_err) begin
              res.verdict = V_FAILED;
            end else begin
              if (frames_since_resync != 16'hffff) frames_since_resync++;
              if (first_pkt_num == 0 && num == len - 1) begin
                reject_count = '0;
                res.recovered_after = hard_resets;
                hard_resets = '0;
                if (!cfg_seg_only || (frame_seg >= 1 && frame_seg <= 4))
                  res.verdict = V_PUBLISHED;
                else
                  res.verdict = V_UNPUBLISHED;
              end else begin
                if (reject_count != 8'hff) reject_count++;
                if (reject_count >= cfg_desync_limit) begin
                  if (hard_resets != 8'hff) hard_resets++;
                  reject_count = '0;
                  frames_since_resync = 16'd3;
                  res.verdict = V_RESET_HUNT;
                end else if (frames_since_resync > 2) begin
                  res.verdict = V_REJECT_HUNT;
                end else begin
                  res.verdict = V_REJECTED;
                end
                if (res.verdict != V_REJECTED) begin
                  sync_mode = MODE_HUNT;
                  hunt_count = '0;
                end
              end
            end
          end
        end
        MODE_HUNT: begin
          give_up = hunt_count >= cfg_hunt_limit;
          keep = ok && ((hdr & DISCARD_MASK) == DISCARD_MASK || num != 0 || crc == 0);
          if (!give_up) hunt_count++;
          if (give_up || !keep) begin
            frame_err = give_up;
            pkt_index = '0;
            sync_mode = MODE_DRAIN;
          end
        end
        MODE_DRAIN: begin
          pkt_index = pkt_index + 1'b1;
          if (pkt_index >= len - 1) begin
            res.verdict = frame_err ? V_HUNT_GAVE_UP : V_HUNT_ENDED;
            frames_since_resync = '0;
            sync_mode = MODE_IDLE;
          end
        end
        default: ;
      endcase
    end
    res.segment = frame_seg;
    res.desync_run = reject_count;
    res.frame_number = frames_since_resync;
    return res;
  endfunction

  always @(posedge clk) begin
    sync_result_t exp_res;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (verdict !== exp_res.verdict) begin
          $error("verdict: expected %0d, actual %0d", exp_res.verdict, verdict);
          mismatch_count++;
        end
        if (segment !== exp_res.segment) begin
          $error("segment: expected %0d, actual %0d", exp_res.segment, segment);
          mismatch_count++;
        end
        if (desync_run !== exp_res.desync_run) begin
          $error("desync_run: expected %0d, actual %0d", exp_res.desync_run, desync_run);
          mismatch_count++;
        end
        if (recovered_after !== exp_res.recovered_after) begin
          $error("recovered_after: expected %0d, actual %0d", exp_res.recovered_after,
                 recovered_after);
          mismatch_count++;
        end
        if (frame_number !== exp_res.frame_number) begin
          $error("frame_number: expected %0d, actual %0d", exp_res.frame_number,
                 frame_number);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_bursts && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic op, input logic [HEADER_W-1:0] hdr,
                           input logic [CRC_W-1:0] crc, input logic ok);
    if (idle_bursts && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    operation <= op;
    header <= hdr;
    crc_word <= crc;
    transfer_ok <= ok;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(track_sync(op, hdr, crc, ok));
  endtask

  task automatic send_random_word(input logic op);
    logic [HEADER_W-1:0] hdr;
    logic [CRC_W-1:0] crc;
    logic ok;
    hdr = HEADER_W'($urandom);
    crc = ($urandom_range(0, 7) == 0) ? '0 : CRC_W'($urandom);
    ok = 1'($urandom_range(0, 1));
    send_word(op, hdr, crc, ok);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SENSOR_IS_SEGMENTED: cfg_seg_only = data[0];
      REG_TELEMETRY_LINES:     cfg_telem = data[TELEM_W-1:0];
      REG_DESYNC_LIMIT:        cfg_desync_limit = data[RUN_W-1:0];
      REG_HUNT_LIMIT:          cfg_hunt_limit = data[HUNT_W-1:0];
      default: ;
    endcase
  endtask

  // err_at and pulse_at below zero disable the transfer error and the stray frame start
  task automatic send_frame(input int first_num, input int last_num, input int seg,
                            input int err_at, input int pulse_at, input int cut_at);
    int len;
    logic [HEADER_W-1:0] hdr;
    logic [CRC_W-1:0] crc;
    len = packets_per_frame();
    send_random_word(OP_FRAME_START);
    for (int i = 0; i < len && i != cut_at; i++) begin
      if (i == pulse_at) send_random_word(OP_FRAME_START);
      hdr = HEADER_W'($urandom);
      crc = CRC_W'($urandom);
      hdr[7:0] = 8'((i == 0) ? first_num : (i == len - 1) ? last_num : i);
      if (i == SEGMENT_PACKET) hdr[14:12] = 3'(seg);
      send_word(OP_PACKET, hdr, crc, i != err_at);
    end
  endtask

  task automatic send_good_frame(input int seg);
    send_frame(0, packets_per_frame() - 1, seg, -1, -1, -1);
  endtask

  task automatic recover_sync(input int junk, input logic end_err);
    int n;
    logic [HEADER_W-1:0] hdr;
    logic [CRC_W-1:0] crc;
    n = 0;
    while (sync_mode == MODE_HUNT) begin
      hdr = HEADER_W'($urandom);
      crc = CRC_W'($urandom);
      if (n < junk) begin
        case ($urandom_range(0, 2))
          0: hdr[11:8] = 4'hf;
          1: if (hdr[7:0] == 0) hdr[7:0] = 8'd1;
          default: crc = '0;
        endcase
        send_word(OP_PACKET, hdr, crc, 1'b1);
      end else if (end_err) begin
        send_word(OP_PACKET, hdr, crc, 1'b0);
      end else begin
        hdr[7:0] = '0;
        if (hdr[11:8] == 4'hf) hdr[11:8] = 4'h0;
        if (crc == 0) crc = 16'h0001;
        send_word(OP_PACKET, hdr, crc, 1'b1);
      end
      n++;
    end
    while (sync_mode == MODE_DRAIN) send_random_word(OP_PACKET);
  endtask

  task automatic test_idle_and_defaults();
    send_word(OP_PACKET, 16'hffff, 16'hffff, 1'b1);
    send_word(OP_PACKET, 16'h0000, 16'h0000, 1'b0);
    send_frame(0, IMAGE_PACKETS - 1, 7, -1, 10, -1);
  endtask

  task automatic test_segment_publish();
    write_reg(REG_SENSOR_IS_SEGMENTED, 12'd1);
    write_reg(REG_TELEMETRY_LINES, 12'd7);
    send_good_frame(0);
    write_reg(REG_TELEMETRY_LINES, 12'd4);
    send_good_frame(4);
    send_good_frame(5);
    write_reg(REG_SENSOR_IS_SEGMENTED, 12'd0);
    write_reg(REG_TELEMETRY_LINES, 12'd0);
  endtask

  task automatic test_transfer_error();
    send_frame(0, packets_per_frame() - 1, 3, packets_per_frame() - 1, -1, -1);
  endtask

  task automatic test_reject_and_hunt();
    send_frame(8'hff, packets_per_frame() - 1, 1, -1, -1, -1);
    recover_sync(6, 1'b0);
    send_frame(0, 0, 1, -1, -1, -1);
  endtask

  task automatic test_hard_reset();
    write_reg(REG_DESYNC_LIMIT, 12'd1);
    write_reg(REG_HUNT_LIMIT, 12'd0);
    send_frame(1, packets_per_frame() - 1, 4, -1, -1, -1);
    recover_sync(0, 1'b0);
    write_reg(REG_DESYNC_LIMIT, 12'd0);
    send_frame(0, 3, 4, -1, -1, -1);
    write_reg(REG_HUNT_LIMIT, 12'd1);
    recover_sync(3, 1'b0);
    write_reg(REG_DESYNC_LIMIT, CFG_DATA_W'(DESYNC_LIMIT_RESET));
    write_reg(REG_HUNT_LIMIT, CFG_DATA_W'(HUNT_LIMIT_RESET));
  endtask

  task automatic test_stall_pressure();
    long_hold_req = 1'b1;
    send_good_frame(2);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int words);
    int target;
    int pick;
    int len;
    write_reg(REG_SENSOR_IS_SEGMENTED, CFG_DATA_W'($urandom_range(0, 1)));
    write_reg(REG_TELEMETRY_LINES, CFG_DATA_W'($urandom_range(0, 7)));
    write_reg(REG_DESYNC_LIMIT, CFG_DATA_W'($urandom_range(0, 6)));
    write_reg(REG_HUNT_LIMIT,
              CFG_DATA_W'(($urandom_range(0, 4) == 0) ? 4095 : $urandom_range(0, 12)));
    target = live_words + words;
    while (live_words < target) begin
      pick = $urandom_range(0, 99);
      len = packets_per_frame();
      if (pick < 65) begin
        send_frame(0, len - 1, $urandom_range(0, 7), -1,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1, -1);
      end else if (pick < 78) begin
        if ($urandom_range(0, 1) == 1)
          send_frame($urandom_range(0, 255), len - 1, $urandom_range(0, 7), -1, -1, -1);
        else
          send_frame(0, $urandom_range(0, 255), $urandom_range(0, 7), -1, -1, -1);
      end else if (pick < 85) begin
        send_frame(0, len - 1, $urandom_range(0, 7), $urandom_range(0, len - 1), -1, -1);
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4)) send_random_word(1'($urandom_range(0, 1)));
      end else begin
        send_frame(0, len - 1, $urandom_range(0, 7), -1, -1, $urandom_range(1, len - 2));
      end
      recover_sync($urandom_range(0, 8), $urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_idle_and_defaults();
    test_segment_publish();
    test_transfer_error();
    test_reject_and_hunt();
    test_hard_reset();
    test_stall_pressure();
    test_random_traffic(200);
    idle_bursts = 1'b0;
    test_random_traffic(100);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/tpfs_pkg.sv
sv/thermal_packet_frame_sync.sv
sim/thermal_packet_frame_sync_tb.sv
